@@ design/ham_pkg.sv @@
// ----------------------------------------------------------------------------
// ham_pkg - shared types and constants of the hysteresis alarm monitor
// Sizes, register map, item modes, sequencer states and the records that
// travel between the sequencer, the slot table, the event ring and the
// config registers.
// ----------------------------------------------------------------------------
package ham_pkg;

  localparam int DEVICE_SLOTS = 16;
  localparam int EVENT_DEPTH  = 16;

  localparam int SLOT_W = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(DEVICE_SLOTS + 1);
  localparam int EV_AW  = $clog2(EVENT_DEPTH);
  localparam int EV_CW  = $clog2(EVENT_DEPTH + 1);

  // operand width of the compare unit: 15 bit signed +/- 13 bit margin
  localparam int OPW = 17;

  // item modes
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_MARK   = 2'd2;

  // register map (word index)
  localparam int PADDR_W = 5;
  localparam logic [2:0] REG_TEMP_HI   = 3'd0;
  localparam logic [2:0] REG_TEMP_LO   = 3'd1;
  localparam logic [2:0] REG_HUM_HI    = 3'd2;
  localparam logic [2:0] REG_HUM_LO    = 3'd3;
  localparam logic [2:0] REG_TEMP_HYST = 3'd4;
  localparam logic [2:0] REG_HUM_HYST  = 3'd5;

  localparam logic signed [14:0] RST_TEMP_HI   = 15'sd4000;
  localparam logic signed [14:0] RST_TEMP_LO   = 15'sd500;
  localparam logic [13:0]        RST_HUM_HI    = 14'd8000;
  localparam logic [13:0]        RST_HUM_LO    = 14'd2000;
  localparam logic [12:0]        RST_TEMP_HYST = 13'd100;
  localparam logic [12:0]        RST_HUM_HYST  = 13'd500;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_JUDGE,
    ST_COMMIT,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [14:0] temp_hi;
    logic signed [14:0] temp_lo;
    logic [13:0]        hum_hi;
    logic [13:0]        hum_lo;
    logic [12:0]        temp_hyst;
    logic [12:0]        hum_hyst;
  } cfg_t;

  typedef struct packed {
    logic [15:0] device;
    logic [2:0]  kind;
    logic [14:0] reading;
    logic [14:0] limit;
    logic [47:0] stamp;
  } event_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  typedef struct packed {
    logic              alloc;
    logic              set_pend;
    logic              clr_pend;
    logic [SLOT_W-1:0] idx;
    logic [15:0]       key;
    logic [3:0]        flags;
  } slot_wr_t;

  typedef struct packed {
    logic        in_use;
    logic [15:0] key;
    logic [3:0]  flags;
    logic        pending;
  } slot_rd_t;

endpackage

@@ design/ham_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ham_cfg_regs - APB register file
// Six threshold and margin registers, written in the access phase and read
// back sign- or zero-extended to 32 bits.
// ----------------------------------------------------------------------------
module ham_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ham_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ham_pkg::cfg_t               cfg_o
);
  import ham_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_hi   <= RST_TEMP_HI;
      cfg_q.temp_lo   <= RST_TEMP_LO;
      cfg_q.hum_hi    <= RST_HUM_HI;
      cfg_q.hum_lo    <= RST_HUM_LO;
      cfg_q.temp_hyst <= RST_TEMP_HYST;
      cfg_q.hum_hyst  <= RST_HUM_HYST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TEMP_HI:   cfg_q.temp_hi   <= pwdata[14:0];
        REG_TEMP_LO:   cfg_q.temp_lo   <= pwdata[14:0];
        REG_HUM_HI:    cfg_q.hum_hi    <= pwdata[13:0];
        REG_HUM_LO:    cfg_q.hum_lo    <= pwdata[13:0];
        REG_TEMP_HYST: cfg_q.temp_hyst <= pwdata[12:0];
        REG_HUM_HYST:  cfg_q.hum_hyst  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TEMP_HI:   prdata = {{17{cfg_q.temp_hi[14]}}, cfg_q.temp_hi};
      REG_TEMP_LO:   prdata = {{17{cfg_q.temp_lo[14]}}, cfg_q.temp_lo};
      REG_HUM_HI:    prdata = {18'd0, cfg_q.hum_hi};
      REG_HUM_LO:    prdata = {18'd0, cfg_q.hum_lo};
      REG_TEMP_HYST: prdata = {19'd0, cfg_q.temp_hyst};
      REG_HUM_HYST:  prdata = {19'd0, cfg_q.hum_hyst};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

@@ design/ham_slot_table.sv @@
// ----------------------------------------------------------------------------
// ham_slot_table - device slot table
// Per-slot in-use bit, key, alarm flags and publish-pending mark, one read
// port at a sequencer-chosen slot and one write command per cycle.
// ----------------------------------------------------------------------------
module ham_slot_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ham_pkg::SLOT_W-1:0]        rd_idx_i,
  input  ham_pkg::slot_wr_t                 wr_i,
  output ham_pkg::slot_rd_t                 rd_o,
  output logic [ham_pkg::CNT_W-1:0]         known_o
);
  import ham_pkg::*;

  logic              in_use_q [DEVICE_SLOTS];
  logic              pend_q   [DEVICE_SLOTS];
  logic [15:0]       key_q    [DEVICE_SLOTS];
  logic [3:0]        flags_q  [DEVICE_SLOTS];
  logic [CNT_W-1:0]  known_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEVICE_SLOTS; i++) begin
        in_use_q[i] <= 1'b0;
        pend_q[i]   <= 1'b0;
      end
      known_q <= '0;
    end else begin
      if (wr_i.alloc) begin
        in_use_q[wr_i.idx] <= 1'b1;
        pend_q[wr_i.idx]   <= 1'b0;
        known_q            <= known_q + CNT_W'(1);
      end
      if (wr_i.set_pend) begin
        pend_q[wr_i.idx] <= 1'b1;
      end
      if (wr_i.clr_pend) begin
        pend_q[wr_i.idx] <= 1'b0;
      end
    end
  end

  // keys stay undefined until a slot is taken; flags are cleared on allocation
  always_ff @(posedge clk_i) begin
    if (wr_i.alloc) begin
      key_q[wr_i.idx]   <= wr_i.key;
      flags_q[wr_i.idx] <= 4'd0;
    end
    if (wr_i.set_pend) begin
      flags_q[wr_i.idx] <= wr_i.flags;
    end
  end

  always_comb begin
    rd_o.in_use  = in_use_q[rd_idx_i];
    rd_o.key     = key_q[rd_idx_i];
    rd_o.flags   = flags_q[rd_idx_i];
    rd_o.pending = pend_q[rd_idx_i];
  end

  assign known_o = known_q;

endmodule

@@ design/ham_event_ring.sv @@
// ----------------------------------------------------------------------------
// ham_event_ring - event queue
// Ring of event records with head pointer and fill count. A push on a full
// ring overwrites the oldest entry. The head entry is read every cycle into
// a register.
// ----------------------------------------------------------------------------
module ham_event_ring (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ham_pkg::ring_cmd_t          cmd_i,
  input  ham_pkg::event_t             ev_i,
  output ham_pkg::event_t             head_o,
  output logic [ham_pkg::EV_CW-1:0]   fill_o,
  output logic                        full_o
);
  import ham_pkg::*;

  event_t           mem [EVENT_DEPTH];
  event_t           head_q;
  logic [EV_AW-1:0] ptr_q;
  logic [EV_CW-1:0] fill_q;
  logic [EV_AW-1:0] ptr_inc;
  logic [EV_AW-1:0] wr_addr;
  logic [EV_CW:0]   tail_sum;

  assign full_o   = (fill_q == EV_CW'(EVENT_DEPTH));
  assign ptr_inc  = (ptr_q == EV_AW'(EVENT_DEPTH - 1)) ? '0 : ptr_q + EV_AW'(1);
  assign tail_sum = (EV_CW + 1)'(ptr_q) + (EV_CW + 1)'(fill_q);

  always_comb begin
    if (full_o) begin
      wr_addr = ptr_q;
    end else if (tail_sum >= (EV_CW + 1)'(EVENT_DEPTH)) begin
      wr_addr = EV_AW'(tail_sum - (EV_CW + 1)'(EVENT_DEPTH));
    end else begin
      wr_addr = EV_AW'(tail_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
    end else if (cmd_i.push) begin
      if (full_o) begin
        ptr_q <= ptr_inc;
      end else begin
        fill_q <= fill_q + EV_CW'(1);
      end
    end else if (cmd_i.pop && (fill_q != '0)) begin
      ptr_q  <= ptr_inc;
      fill_q <= fill_q - EV_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_addr] <= ev_i;
    end
    head_q <= mem[ptr_q];
  end

  assign head_o = head_q;
  assign fill_o = fill_q;

endmodule

@@ design/ham_judge_unit.sv @@
// ----------------------------------------------------------------------------
// ham_judge_unit - shared alarm compare unit
// Decides one alarm transition: start when the reading passes the limit,
// end when it has come back by the margin. Used for all four alarms in turn.
// ----------------------------------------------------------------------------
module ham_judge_unit (
  input  logic signed [ham_pkg::OPW-1:0] value_i,
  input  logic signed [ham_pkg::OPW-1:0] limit_i,
  input  logic signed [ham_pkg::OPW-1:0] hyst_i,
  input  logic                           is_low_i,
  input  logic                           active_i,
  output logic                           hit_o
);
  import ham_pkg::*;

  logic signed [OPW-1:0] bound;

  // low alarm ends at or above limit + margin, high alarm at or below limit - margin
  always_comb begin
    if (!active_i) begin
      bound = limit_i;
    end else if (is_low_i) begin
      bound = limit_i + hyst_i;
    end else begin
      bound = limit_i - hyst_i;
    end
  end

  always_comb begin
    case ({active_i, is_low_i})
      2'b00:   hit_o = (value_i >  bound);
      2'b01:   hit_o = (value_i <  bound);
      2'b10:   hit_o = (value_i <= bound);
      2'b11:   hit_o = (value_i >= bound);
      default: hit_o = 1'b0;
    endcase
  end

endmodule

@@ design/hysteresis_alarm_event_monitor.sv @@
// ----------------------------------------------------------------------------
// hysteresis_alarm_event_monitor - device alarm monitor with event queue
// Looks up or allocates a device slot, runs the four hysteresis alarms
// through one shared compare unit and queues start/end events in a ring.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  mode .. timestamp
//   out      output     out_valid_o / out_stall_i accepted .. publish_pending
//   cfg      input      APB psel/penable/pready  six limit/margin registers
//
// From acceptance to the result register the slot scan (one slot per cycle)
// visits every slot, then decide, read and done follow; a sample that finds or
// takes a slot adds four alarm steps and a commit step after decide. A new
// item is only taken once the last one has left the done state.
// in_stall_o is high from acceptance until the result is loaded into the
// output register; while an earlier result is still stalled the block holds
// in its done state. The next item is taken while a loaded result waits.
// Reset leaves the slot table and queue empty and the result invalid; no clearing pass.
// ----------------------------------------------------------------------------
module hysteresis_alarm_event_monitor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  mode_i,
  input  logic [15:0]                 device_key_i,
  input  logic                        has_temperature_i,
  input  logic signed [14:0]          temperature_i,
  input  logic                        has_humidity_i,
  input  logic [13:0]                 humidity_i,
  input  logic [47:0]                 timestamp_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        accepted_o,
  output logic                        head_valid_o,
  output logic [15:0]                 head_device_o,
  output logic [2:0]                  head_kind_o,
  output logic signed [14:0]          head_reading_o,
  output logic signed [14:0]          head_limit_o,
  output logic [47:0]                 head_time_o,
  output logic [4:0]                  queued_events_o,
  output logic [4:0]                  known_devices_o,
  output logic                        events_overwritten_o,
  output logic                        publish_pending_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ham_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ham_pkg::*;

  cfg_t             cfg;
  slot_rd_t         slot_rd;
  slot_wr_t         slot_wr;
  logic [SLOT_W-1:0] slot_idx;
  logic [SLOT_W-1:0] sel_idx;
  logic [CNT_W-1:0] known;
  ring_cmd_t        ring_cmd;
  event_t           ring_ev;
  event_t           head_ev;
  logic [EV_CW-1:0] fill;
  logic             ring_full;

  state_e state_q, state_d;

  // item registers
  logic [1:0]         mode_q;
  logic [15:0]        key_q;
  logic               has_t_q;
  logic signed [14:0] temp_q;
  logic               has_h_q;
  logic [13:0]        hum_q;
  logic [47:0]        stamp_q;

  // sequencer registers
  logic [SLOT_W-1:0] scan_q;
  logic              found_q;
  logic [SLOT_W-1:0] found_idx_q;
  logic              free_q;
  logic [SLOT_W-1:0] free_idx_q;
  logic [1:0]        step_q;
  logic [3:0]        flags_q;
  logic              acc_q;
  logic              ovw_q;
  logic              pend_q;
  logic              out_valid_q;

  // compare unit operands
  logic signed [OPW-1:0] op_value;
  logic signed [OPW-1:0] op_limit;
  logic signed [OPW-1:0] op_hyst;
  logic                  op_active;
  logic                  op_enable;
  logic                  op_hit;
  logic                  push;
  logic                  in_take;
  logic                  out_free;
  logic                  scan_last;

  ham_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ham_slot_table u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (slot_idx),
    .wr_i     (slot_wr),
    .rd_o     (slot_rd),
    .known_o  (known)
  );

  ham_event_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (ring_cmd),
    .ev_i   (ring_ev),
    .head_o (head_ev),
    .fill_o (fill),
    .full_o (ring_full)
  );

  ham_judge_unit u_judge (
    .value_i  (op_value),
    .limit_i  (op_limit),
    .hyst_i   (op_hyst),
    .is_low_i (step_q[0]),
    .active_i (op_active),
    .hit_o    (op_hit)
  );

  assign in_take   = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign scan_last = (scan_q == SLOT_W'(DEVICE_SLOTS - 1));
  assign sel_idx   = found_q ? found_idx_q : free_idx_q;
  assign slot_idx  = (state_q == ST_SCAN) ? scan_q : sel_idx;

  // step: bit 1 picks humidity, bit 0 picks the low alarm
  always_comb begin
    if (step_q[1]) begin
      op_value  = OPW'(signed'({1'b0, hum_q}));
      op_limit  = step_q[0] ? OPW'(signed'({1'b0, cfg.hum_lo}))
                            : OPW'(signed'({1'b0, cfg.hum_hi}));
      op_hyst   = OPW'(signed'({1'b0, cfg.hum_hyst}));
      op_enable = has_h_q;
    end else begin
      op_value  = OPW'(temp_q);
      op_limit  = step_q[0] ? OPW'(cfg.temp_lo) : OPW'(cfg.temp_hi);
      op_hyst   = OPW'(signed'({1'b0, cfg.temp_hyst}));
      op_enable = has_t_q;
    end
    op_active = flags_q[step_q];
  end

  assign push = (state_q == ST_JUDGE) && op_enable && op_hit;

  always_comb begin
    ring_ev.device  = key_q;
    ring_ev.kind    = {step_q, op_active};
    ring_ev.reading = op_value[14:0];
    ring_ev.limit   = op_limit[14:0];
    ring_ev.stamp   = stamp_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if ((mode_q == MODE_SAMPLE) && (found_q || free_q)) state_d = ST_JUDGE;
        else state_d = ST_READ;
      end
      ST_JUDGE: begin
        if (step_q == 2'd3) state_d = ST_COMMIT;
      end
      ST_COMMIT: state_d = ST_READ;
      ST_READ:   state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // slot and ring commands
  always_comb begin
    slot_wr          = '0;
    slot_wr.idx      = sel_idx;
    slot_wr.key      = key_q;
    slot_wr.flags    = flags_q;
    ring_cmd         = '0;
    ring_cmd.push    = push;
    case (state_q)
      ST_DECIDE: begin
        if ((mode_q == MODE_SAMPLE) && !found_q && free_q) slot_wr.alloc = 1'b1;
        if ((mode_q == MODE_MARK) && found_q) slot_wr.clr_pend = 1'b1;
        if (mode_q == MODE_POP) ring_cmd.pop = 1'b1;
      end
      ST_COMMIT: slot_wr.set_pend = 1'b1;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q  <= mode_i;
      key_q   <= device_key_i;
      has_t_q <= has_temperature_i;
      temp_q  <= temperature_i;
      has_h_q <= has_humidity_i;
      hum_q   <= humidity_i;
      stamp_q <= timestamp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      step_q      <= '0;
      flags_q     <= '0;
      acc_q       <= 1'b0;
      ovw_q       <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          scan_q  <= '0;
          found_q <= 1'b0;
          free_q  <= 1'b0;
          ovw_q   <= 1'b0;
          acc_q   <= 1'b0;
        end
        ST_SCAN: begin
          if (slot_rd.in_use && (slot_rd.key == key_q) && !found_q) begin
            found_q     <= 1'b1;
            found_idx_q <= scan_q;
          end
          if (!slot_rd.in_use && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= scan_q;
          end
          scan_q <= scan_q + SLOT_W'(1);
        end
        ST_DECIDE: begin
          step_q  <= '0;
          flags_q <= found_q ? slot_rd.flags : 4'd0;
          case (mode_q)
            MODE_SAMPLE: begin
              acc_q  <= found_q || free_q;
              pend_q <= 1'b0;
            end
            MODE_POP: begin
              acc_q  <= (fill != '0);
              pend_q <= found_q && slot_rd.pending;
            end
            MODE_MARK: begin
              acc_q  <= found_q;
              pend_q <= 1'b0;
            end
            default: begin
              acc_q  <= 1'b0;
              pend_q <= found_q && slot_rd.pending;
            end
          endcase
        end
        ST_JUDGE: begin
          step_q <= step_q + 2'd1;
          if (push) begin
            flags_q[step_q] <= !op_active;
            if (ring_full) ovw_q <= 1'b1;
          end
        end
        ST_COMMIT: pend_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      accepted_o           <= acc_q;
      head_valid_o         <= (fill != '0);
      head_device_o        <= (fill != '0) ? head_ev.device  : 16'd0;
      head_kind_o          <= (fill != '0) ? head_ev.kind    : 3'd0;
      head_reading_o       <= (fill != '0) ? head_ev.reading : 15'd0;
      head_limit_o         <= (fill != '0) ? head_ev.limit   : 15'd0;
      head_time_o          <= (fill != '0) ? head_ev.stamp   : 48'd0;
      queued_events_o      <= 5'(fill);
      known_devices_o      <= 5'(known);
      events_overwritten_o <= ovw_q;
      publish_pending_o    <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/ham_checker.sv @@
// ----------------------------------------------------------------------------
// ham_checker - port-level checks of the alarm monitor
// Watches the result channel and the input handshake; bound to the top.
// ----------------------------------------------------------------------------
module ham_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               accepted_o,
  input logic               head_valid_o,
  input logic [15:0]        head_device_o,
  input logic [2:0]         head_kind_o,
  input logic signed [14:0] head_reading_o,
  input logic signed [14:0] head_limit_o,
  input logic [47:0]        head_time_o,
  input logic [4:0]         queued_events_o,
  input logic [4:0]         known_devices_o,
  input logic               events_overwritten_o
);
  import ham_pkg::*;

  // head fields reflect an empty queue exactly
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_valid_o == (queued_events_o != 5'd0)))
    else $error("head_valid disagrees with queued_events");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !head_valid_o |-> (head_device_o == 16'd0) && (head_kind_o == 3'd0)
      && (head_reading_o == 15'sd0) && (head_limit_o == 15'sd0) && (head_time_o == 48'd0))
    else $error("empty queue shows a head event");

  // an overwrite only happens on a taken sample that leaves the ring full
  a_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && events_overwritten_o |->
      accepted_o && (queued_events_o == 5'(EVENT_DEPTH)))
    else $error("overwrite reported without a full ring");

  // one item at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while first in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(queued_events_o)
      && $stable(known_devices_o) && $stable(accepted_o))
    else $error("stalled result changed");

endmodule

bind hysteresis_alarm_event_monitor ham_checker u_ham_checker (.*);

@@ tb/sv/hysteresis_alarm_event_monitor_test.sv @@
// ----------------------------------------------------------------------------
// hysteresis_alarm_event_monitor_test - self-checking bench of the alarm monitor
// A queue of requests feeds a clocked driver; a clocked monitor predicts each
// accepted request against a private copy of the slot table, the event ring and
// the limit registers, and checks every result field by field. Directed cases
// first, then random phases under several limit settings with random idling.
// ----------------------------------------------------------------------------
module hysteresis_alarm_event_monitor_test;
  import ham_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // event kinds: base per reading plus offset per alarm edge
  localparam logic [2:0] KIND_TEMP     = 3'd0;
  localparam logic [2:0] KIND_HUM      = 3'd4;
  localparam logic [2:0] KIND_HI_START = 3'd0;
  localparam logic [2:0] KIND_HI_END   = 3'd1;
  localparam logic [2:0] KIND_LO_START = 3'd2;
  localparam logic [2:0] KIND_LO_END   = 3'd3;
  localparam int FLAG_TEMP = 0;
  localparam int FLAG_HUM  = 2;

  localparam int TEMP_MIN = -4000;
  localparam int TEMP_MAX = 12500;
  localparam int HUM_MAX  = 10000;
  localparam int HYST_MAX = 5000;

  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 2000;

  typedef struct {
    logic [1:0]         mode;
    logic [15:0]        key;
    logic               has_t;
    logic signed [14:0] temp;
    logic               has_h;
    logic [13:0]        hum;
    logic [47:0]        ts;
  } request_t;

  typedef struct {
    logic               accepted;
    logic               head_valid;
    logic [15:0]        head_device;
    logic [2:0]         head_kind;
    logic signed [14:0] head_reading;
    logic signed [14:0] head_limit;
    logic [47:0]        head_time;
    logic [4:0]         queued_events;
    logic [4:0]         known_devices;
    logic               events_overwritten;
    logic               publish_pending;
  } status_t;

  logic               clk_i;
  logic               rst_ni            = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i            = MODE_SAMPLE;
  logic [15:0]        device_key_i      = '0;
  logic               has_temperature_i = 1'b0;
  logic signed [14:0] temperature_i     = '0;
  logic               has_humidity_i    = 1'b0;
  logic [13:0]        humidity_i        = '0;
  logic [47:0]        timestamp_i       = '0;
  logic               out_valid_o;
  logic               out_stall_i       = 1'b0;
  logic               accepted_o;
  logic               head_valid_o;
  logic [15:0]        head_device_o;
  logic [2:0]         head_kind_o;
  logic signed [14:0] head_reading_o;
  logic signed [14:0] head_limit_o;
  logic [47:0]        head_time_o;
  logic [4:0]         queued_events_o;
  logic [4:0]         known_devices_o;
  logic               events_overwritten_o;
  logic               publish_pending_o;
  logic               psel              = 1'b0;
  logic               penable           = 1'b0;
  logic               pwrite            = 1'b0;
  logic [PADDR_W-1:0] paddr             = '0;
  logic [31:0]        pwdata            = '0;
  logic [31:0]        prdata;
  logic               pready;

  hysteresis_alarm_event_monitor dut (.*);

  // limit registers as the block should hold them
  int cfg_temp_hi   = RST_TEMP_HI;
  int cfg_temp_lo   = RST_TEMP_LO;
  int cfg_hum_hi    = RST_HUM_HI;
  int cfg_hum_lo    = RST_HUM_LO;
  int cfg_temp_hyst = RST_TEMP_HYST;
  int cfg_hum_hyst  = RST_HUM_HYST;

  // device table and event ring
  logic        slot_used  [DEVICE_SLOTS] = '{default: 1'b0};
  logic [15:0] slot_id    [DEVICE_SLOTS];
  logic [3:0]  slot_flags [DEVICE_SLOTS];
  logic        slot_pend  [DEVICE_SLOTS] = '{default: 1'b0};
  logic [15:0] ev_dev     [EVENT_DEPTH];
  logic [2:0]  ev_kind    [EVENT_DEPTH];
  logic [14:0] ev_reading [EVENT_DEPTH];
  logic [14:0] ev_limit   [EVENT_DEPTH];
  logic [47:0] ev_time    [EVENT_DEPTH];
  int          ev_head  = 0;
  int          ev_count = 0;
  logic        ev_dropped;

  request_t pending_requests[$];
  status_t  expected_status[$];

  int items_sent     = 0;
  int items_taken    = 0;
  int results_taken  = 0;
  int stall_drawn_at = -1;
  int hold_left      = 0;
  int stall_left     = 0;
  int quiet_cycles   = 0;
  int mismatch_count = 0;
  bit calm_phase     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int find_slot(logic [15:0] key);
    int s;
    s = -1;
    for (int i = DEVICE_SLOTS - 1; i >= 0; i--)
      if (slot_used[i] && slot_id[i] == key) s = i;
    return s;
  endfunction

  function automatic void ring_push(logic [15:0] dev, logic [2:0] kind, int reading,
                                    int limit, logic [47:0] ts);
    int w;
    if (ev_count < EVENT_DEPTH) begin
      w = (ev_head + ev_count) % EVENT_DEPTH;
      ev_count++;
    end else begin
      // full ring: oldest event gives way
      w = ev_head;
      ev_head = (ev_head + 1) % EVENT_DEPTH;
      ev_dropped = 1'b1;
    end
    ev_dev[w]     = dev;
    ev_kind[w]    = kind;
    ev_reading[w] = reading[14:0];
    ev_limit[w]   = limit[14:0];
    ev_time[w]    = ts;
  endfunction

  function automatic void judge_alarms(int s, int value, int hi, int lo, int margin,
                                       logic [2:0] base, int hb, logic [47:0] ts);
    logic [15:0] dev;
    dev = slot_id[s];
    if (!slot_flags[s][hb] && value > hi) begin
      slot_flags[s][hb] = 1'b1;
      ring_push(dev, 3'(base + KIND_HI_START), value, hi, ts);
    end else if (slot_flags[s][hb] && value <= hi - margin) begin
      slot_flags[s][hb] = 1'b0;
      ring_push(dev, 3'(base + KIND_HI_END), value, hi, ts);
    end
    if (!slot_flags[s][hb+1] && value < lo) begin
      slot_flags[s][hb+1] = 1'b1;
      ring_push(dev, 3'(base + KIND_LO_START), value, lo, ts);
    end else if (slot_flags[s][hb+1] && value >= lo + margin) begin
      slot_flags[s][hb+1] = 1'b0;
      ring_push(dev, 3'(base + KIND_LO_END), value, lo, ts);
    end
  endfunction

  function automatic status_t predict_status(request_t rq);
    status_t r;
    int s;
    int known;
    r = '{default: '0};
    ev_dropped = 1'b0;
    s = find_slot(rq.key);
    case (rq.mode)
      MODE_SAMPLE: begin
        // first sight of a key takes the lowest free slot
        for (int i = 0; i < DEVICE_SLOTS; i++)
          if (s < 0 && !slot_used[i]) begin
            slot_used[i]  = 1'b1;
            slot_id[i]    = rq.key;
            slot_flags[i] = '0;
            slot_pend[i]  = 1'b0;
            s = i;
          end
        if (s >= 0) begin
          if (rq.has_t)
            judge_alarms(s, int'(rq.temp), cfg_temp_hi, cfg_temp_lo, cfg_temp_hyst,
                         KIND_TEMP, FLAG_TEMP, rq.ts);
          if (rq.has_h)
            judge_alarms(s, int'(rq.hum), cfg_hum_hi, cfg_hum_lo, cfg_hum_hyst,
                         KIND_HUM, FLAG_HUM, rq.ts);
          slot_pend[s] = 1'b1;
          r.accepted = 1'b1;
        end
      end
      MODE_POP: begin
        if (ev_count > 0) begin
          ev_head = (ev_head + 1) % EVENT_DEPTH;
          ev_count--;
          r.accepted = 1'b1;
        end
      end
      MODE_MARK: begin
        if (s >= 0) begin
          slot_pend[s] = 1'b0;
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    known = 0;
    for (int i = 0; i < DEVICE_SLOTS; i++)
      if (slot_used[i]) known++;
    if (ev_count > 0) begin
      r.head_valid   = 1'b1;
      r.head_device  = ev_dev[ev_head];
      r.head_kind    = ev_kind[ev_head];
      r.head_reading = ev_reading[ev_head];
      r.head_limit   = ev_limit[ev_head];
      r.head_time    = ev_time[ev_head];
    end
    r.queued_events      = 5'(ev_count);
    r.known_devices      = 5'(known);
    r.events_overwritten = ev_dropped;
    s = find_slot(rq.key);
    r.publish_pending = (s >= 0) ? slot_pend[s] : 1'b0;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // driver: request payload changes only on the falling edge
  always @(negedge clk_i) begin
    request_t nxt;
    if (rst_ni && items_sent == items_taken) begin
      if (hold_left > 0 || pending_requests.size() == 0) begin
        if (hold_left > 0) hold_left--;
        in_valid_i <= 1'b0;
      end else begin
        nxt = pending_requests.pop_front();
        mode_i            <= nxt.mode;
        device_key_i      <= nxt.key;
        has_temperature_i <= nxt.has_t;
        temperature_i     <= nxt.temp;
        has_humidity_i    <= nxt.has_h;
        humidity_i        <= nxt.hum;
        timestamp_i       <= nxt.ts;
        in_valid_i        <= 1'b1;
        items_sent++;
        hold_left = calm_phase ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // result stall: drawn once per result, occasional stall while nothing waits
  always @(negedge clk_i) begin
    logic stall;
    if (out_valid_o && stall_drawn_at != results_taken) begin
      stall_drawn_at = results_taken;
      stall_left = calm_phase ? 0 : $urandom_range(0, 4);
    end
    if (out_valid_o) begin
      stall = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end else begin
      stall = !calm_phase && ($urandom_range(0, 3) == 0);
    end
    out_stall_i <= stall;
  end

  // monitor: predict on request acceptance, check on result acceptance
  always @(posedge clk_i) begin
    request_t rq;
    status_t  want;
    if (rst_ni) begin
      quiet_cycles++;
      if (out_valid_o && !out_stall_i) begin
        quiet_cycles = 0;
        results_taken++;
        if (expected_status.size() == 0) begin
          $error("result item with no prediction waiting");
          mismatch_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("accepted", want.accepted, accepted_o);
          check_field("head_valid", want.head_valid, head_valid_o);
          check_field("head_device", want.head_device, head_device_o);
          check_field("head_kind", want.head_kind, head_kind_o);
          check_field("head_reading", want.head_reading, head_reading_o);
          check_field("head_limit", want.head_limit, head_limit_o);
          check_field("head_time", want.head_time, head_time_o);
          check_field("queued_events", want.queued_events, queued_events_o);
          check_field("known_devices", want.known_devices, known_devices_o);
          check_field("events_overwritten", want.events_overwritten, events_overwritten_o);
          check_field("publish_pending", want.publish_pending, publish_pending_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        quiet_cycles = 0;
        items_taken++;
        rq.mode  = mode_i;
        rq.key   = device_key_i;
        rq.has_t = has_temperature_i;
        rq.temp  = temperature_i;
        rq.has_h = has_humidity_i;
        rq.hum   = humidity_i;
        rq.ts    = timestamp_i;
        expected_status.push_back(predict_status(rq));
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic reg_write(logic [2:0] idx, int value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TEMP_HI:   cfg_temp_hi   = {{17{value[14]}}, value[14:0]};
      REG_TEMP_LO:   cfg_temp_lo   = {{17{value[14]}}, value[14:0]};
      REG_HUM_HI:    cfg_hum_hi    = value & 32'h3FFF;
      REG_HUM_LO:    cfg_hum_lo    = value & 32'h3FFF;
      REG_TEMP_HYST: cfg_temp_hyst = value & 32'h1FFF;
      REG_HUM_HYST:  cfg_hum_hyst  = value & 32'h1FFF;
      default: ;
    endcase
  endtask

  task automatic program_limits(int thi, int tlo, int hhi, int hlo, int thys, int hhys);
    reg_write(REG_TEMP_HI, thi);
    reg_write(REG_TEMP_LO, tlo);
    reg_write(REG_HUM_HI, hhi);
    reg_write(REG_HUM_LO, hlo);
    reg_write(REG_TEMP_HYST, thys);
    reg_write(REG_HUM_HYST, hhys);
  endtask

  task automatic drain;
    while (pending_requests.size() != 0 || items_sent != items_taken ||
           expected_status.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void add_request(logic [1:0] mode, logic [15:0] key, logic has_t,
                                      int temp, logic has_h, int hum, logic [47:0] ts);
    request_t rq;
    rq.mode  = mode;
    rq.key   = key;
    rq.has_t = has_t;
    rq.temp  = temp[14:0];
    rq.has_h = has_h;
    rq.hum   = hum[13:0];
    rq.ts    = ts;
    pending_requests.push_back(rq);
  endfunction

  // readings cluster around the live limits so alarms actually toggle
  function automatic int pick_reading(int hi, int lo, int margin, int minv, int maxv);
    int v;
    int span;
    case ($urandom_range(0, 7))
      0: v = int'($urandom_range(0, maxv - minv)) + minv;
      1: v = $urandom_range(0, 1) ? minv : maxv;
      default: begin
        span = margin + 20;
        v = ($urandom_range(0, 1) ? hi : lo) + int'($urandom_range(0, 2 * span)) - span;
      end
    endcase
    if (v < minv) v = minv;
    if (v > maxv) v = maxv;
    return v;
  endfunction

  function automatic request_t random_request(int pop_pct);
    request_t rq;
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < pop_pct)           rq.mode = MODE_POP;
    else if (pick < pop_pct + 12) rq.mode = MODE_MARK;
    else if (pick < pop_pct + 15) rq.mode = MODE_UNUSED;
    else                          rq.mode = MODE_SAMPLE;
    // known keys mostly; some strangers that a full table turns away
    k = $urandom_range(0, 15);
    rq.key   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : (k == 15) ? 16'hFFFF : 16'(k);
    rq.has_t = ($urandom_range(0, 4) != 0);
    rq.temp  = 15'(pick_reading(cfg_temp_hi, cfg_temp_lo, cfg_temp_hyst, TEMP_MIN, TEMP_MAX));
    rq.has_h = ($urandom_range(0, 4) != 0);
    rq.hum   = 14'(pick_reading(cfg_hum_hi, cfg_hum_lo, cfg_hum_hyst, 0, HUM_MAX));
    rq.ts    = 48'({$urandom, $urandom});
    return rq;
  endfunction

  task automatic run_random(int count, int pop_pct, bit calm);
    calm_phase = calm;
    repeat (count) pending_requests.push_back(random_request(pop_pct));
    drain();
  endtask

  task automatic run_random_limits(int count, int pop_pct, bit calm);
    program_limits(int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN,
                   int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN,
                   $urandom_range(0, HUM_MAX), $urandom_range(0, HUM_MAX),
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, HYST_MAX) : $urandom_range(0, 600),
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, HYST_MAX) : $urandom_range(0, 600));
    run_random(count, pop_pct, calm);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset limits
    add_request(MODE_POP, 16'h0000, 1'b0, 0, 1'b0, 0, '0);          // pop on empty ring
    add_request(MODE_MARK, 16'h0000, 1'b0, 0, 1'b0, 0, '0);         // mark unknown device
    add_request(MODE_SAMPLE, 16'h0000, 1'b0, 0, 1'b0, 0, '0);       // no readings at all
    add_request(MODE_SAMPLE, 16'hFFFF, 1'b1, TEMP_MAX, 1'b1, 0, '1);
    // four events from one item
    add_request(MODE_SAMPLE, 16'hFFFF, 1'b1, TEMP_MIN, 1'b1, HUM_MAX, 48'h5A5A_0F0F_A5A5);
    add_request(MODE_UNUSED, 16'hFFFF, 1'b1, 0, 1'b1, 0, '1);
    add_request(MODE_MARK, 16'hFFFF, 1'b0, 0, 1'b0, 0, '0);
    add_request(MODE_POP, 16'hFFFF, 1'b0, 0, 1'b0, 0, '0);
    add_request(MODE_SAMPLE, 16'h0001, 1'b1, 4001, 1'b0, 0, 48'd1);
    add_request(MODE_SAMPLE, 16'h0001, 1'b1, 3900, 1'b0, 0, 48'd2); // end right at limit-margin
    add_request(MODE_SAMPLE, 16'h0001, 1'b1, 499, 1'b0, 0, 48'd3);
    add_request(MODE_SAMPLE, 16'h0001, 1'b1, 600, 1'b1, 8001, 48'd4);
    add_request(MODE_SAMPLE, 16'h0001, 1'b0, 0, 1'b1, 7500, 48'd5);
    for (int k = 2; k <= 14; k++)
      add_request(MODE_SAMPLE, 16'(k), 1'b1, 4000, 1'b1, 2000, 48'(k));
    add_request(MODE_SAMPLE, 16'h1234, 1'b1, TEMP_MAX, 1'b1, HUM_MAX, '1); // table full
    drain();

    run_random(100, 25, 1'b0);
    program_limits(TEMP_MAX, TEMP_MIN, HUM_MAX, 0, 0, 0);
    run_random(100, 25, 1'b1);
    program_limits(TEMP_MIN, TEMP_MAX, 0, HUM_MAX, HYST_MAX, HYST_MAX);
    run_random(100, 5, 1'b0);
    run_random_limits(110, 20, 1'b0);
    run_random_limits(110, 8, 1'b1);
    run_random_limits(110, 30, 1'b0);
    run_random_limits(110, 15, 1'b0);

    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
design/ham_pkg.sv
design/ham_cfg_regs.sv
design/ham_slot_table.sv
design/ham_event_ring.sv
design/ham_judge_unit.sv
design/hysteresis_alarm_event_monitor.sv
design/ham_checker.sv
tb/sv/hysteresis_alarm_event_monitor_test.sv
